// ----- hw/rtl/ejs_pkg.sv -----
// ----------------------------------------------------------------------------
// ejs_pkg - shared types and helpers for the JSON string escaper
// Holds the job descriptor passed from classifier to serializer and the
// hex digit table.
// ----------------------------------------------------------------------------
package ejs_pkg;

    // Default depth of the job queue between classifier and serializer
    localparam int EJS_QUEUE_DEPTH = 4;

    // Width of the left-aligned hex payload (five nibbles)
    localparam int EJS_PAYLOAD_W = 20;

    // ASCII codes used by the escaper
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // Largest code point that a four-byte sequence may carry
    localparam logic [20:0] MAX_FOUR_BYTE = 21'h10FFF;

    // Kind of output run a job expands into
    typedef enum logic [2:0] {
        JOB_PASS,   // one character from payload[7:0]
        JOB_ESC2,   // backslash, payload[7:0]
        JOB_ESC3,   // backslash, backslash, payload[7:0]
        JOB_HEX3,   // backslash, u, 0, three hex digits
        JOB_HEX4,   // backslash, u, four hex digits
        JOB_HEX5    // backslash, u, five hex digits
    } job_kind_t;

    // One queued job: hex payloads are left-aligned in the 20-bit field
    typedef struct packed {
        job_kind_t                  kind;
        logic [EJS_PAYLOAD_W-1:0]   payload;
        logic                       str_end;
        logic                       invalid;
    } ejs_job_t;

    // Lowercase hex digit for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        case (nib)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h61;
            4'hB: c = 8'h62;
            4'hC: c = 8'h63;
            4'hD: c = 8'h64;
            4'hE: c = 8'h65;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/ejs_front.sv -----
// ----------------------------------------------------------------------------
// ejs_front - byte classifier
// Tracks the open UTF-8 sequence and turns each accepted byte into at most
// one job for the serializer.
// ----------------------------------------------------------------------------
module ejs_front
    import ejs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        job_valid,
    input  logic        job_ready,
    output ejs_job_t    job
);

    logic [1:0]  bytes_left_reg, bytes_left_next;
    logic [2:0]  seq_length_reg, seq_length_next;
    logic [20:0] code_value_reg, code_value_next;
    logic        error_seen_reg, error_seen_next;

    logic        accept;
    logic        emit;
    logic [20:0] code_cont;
    logic [1:0]  left_dec;

    assign in_ready = job_ready;
    assign accept   = in_valid && job_ready;
    assign job_valid = accept && (emit || in_last);
    assign code_cont = {code_value_reg[14:0], in_byte[5:0]};
    assign left_dec  = bytes_left_reg - 2'd1;

    // Classify the byte and compute the next sequence state
    always_comb begin
        bytes_left_next = bytes_left_reg;
        seq_length_next = seq_length_reg;
        code_value_next = code_value_reg;
        error_seen_next = error_seen_reg;
        emit            = 1'b0;
        job.kind        = JOB_PASS;
        job.payload     = {12'd0, in_byte};
        job.str_end     = in_last;
        job.invalid     = 1'b0;

        if (error_seen_reg) begin
            emit = 1'b0;
        end else if (bytes_left_reg != 2'd0) begin
            code_value_next = code_cont;
            bytes_left_next = left_dec;
            if (left_dec == 2'd0) begin
                seq_length_next = 3'd0;
                code_value_next = 21'd0;
                if (seq_length_reg == 3'd2) begin
                    emit        = 1'b1;
                    job.kind    = JOB_HEX3;
                    job.payload = {code_cont[11:0], 8'd0};
                end else if (seq_length_reg == 3'd3) begin
                    emit        = 1'b1;
                    job.kind    = JOB_HEX4;
                    job.payload = {code_cont[15:0], 4'd0};
                end else if (code_cont <= MAX_FOUR_BYTE) begin
                    emit        = 1'b1;
                    job.kind    = JOB_HEX5;
                    job.payload = code_cont[19:0];
                end
            end
        end else if (!in_byte[7]) begin
            emit = 1'b1;
            case (in_byte)
                CH_QUOTE:  job.kind = JOB_ESC2;
                CH_BSLASH: job.kind = JOB_ESC2;
                CH_BS: begin
                    job.kind    = JOB_ESC3;
                    job.payload = {12'd0, CH_B};
                end
                CH_FF: begin
                    job.kind    = JOB_ESC3;
                    job.payload = {12'd0, CH_F};
                end
                CH_LF: begin
                    job.kind    = JOB_ESC3;
                    job.payload = {12'd0, CH_N};
                end
                CH_CR: begin
                    job.kind    = JOB_ESC3;
                    job.payload = {12'd0, CH_R};
                end
                CH_TAB: begin
                    job.kind    = JOB_ESC3;
                    job.payload = {12'd0, CH_T};
                end
                default: job.kind = JOB_PASS;
            endcase
        end else if (in_byte[7:5] == 3'b110) begin
            seq_length_next = 3'd2;
            bytes_left_next = 2'd1;
            code_value_next = {16'd0, in_byte[4:0]};
        end else if (in_byte[7:4] == 4'b1110) begin
            seq_length_next = 3'd3;
            bytes_left_next = 2'd2;
            code_value_next = {17'd0, in_byte[3:0]};
        end else if (in_byte[7:3] == 5'b11110) begin
            seq_length_next = 3'd4;
            bytes_left_next = 2'd3;
            code_value_next = {18'd0, in_byte[2:0]};
        end else begin
            error_seen_next = 1'b1;
        end

        // Close the string: a silent final byte becomes a pure end result
        if (in_last) begin
            if (!emit) begin
                job.kind    = JOB_PASS;
                job.payload = '0;
                job.invalid = error_seen_next || (bytes_left_next != 2'd0);
            end
            bytes_left_next = 2'd0;
            seq_length_next = 3'd0;
            code_value_next = 21'd0;
            error_seen_next = 1'b0;
        end
    end

    // Advance sequence state on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= 2'd0;
            seq_length_reg <= 3'd0;
            code_value_reg <= 21'd0;
            error_seen_reg <= 1'b0;
        end else if (accept) begin
            bytes_left_reg <= bytes_left_next;
            seq_length_reg <= seq_length_next;
            code_value_reg <= code_value_next;
            error_seen_reg <= error_seen_next;
        end
    end

endmodule

// ----- hw/rtl/ejs_queue.sv -----
// ----------------------------------------------------------------------------
// ejs_queue - job queue
// Small register FIFO that decouples the classifier from the serializer.
// ----------------------------------------------------------------------------
module ejs_queue
    import ejs_pkg::*;
#(
    parameter int DEPTH = EJS_QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    output logic      push_ready,
    input  ejs_job_t  push_job,
    output logic      head_valid,
    input  logic      pop,
    output ejs_job_t  head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ejs_job_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    // Store incoming jobs
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/ejs_back.sv -----
// ----------------------------------------------------------------------------
// ejs_back - character serializer
// Expands the head job into its characters, one per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
module ejs_back
    import ejs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      head_valid,
    input  ejs_job_t  head_job,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output logic [7:0] out_char,
    output logic      out_run_last,
    output logic      out_str_end,
    output logic      out_invalid
);

    logic [2:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       run_last_reg, run_last_next;
    logic       str_end_reg, str_end_next;
    logic       invalid_reg, invalid_next;

    logic [2:0] prefix_len;
    logic [2:0] digit_cnt;
    logic [2:0] digit_idx;
    logic       is_hex;
    logic       last_char;
    logic [3:0] nibble;
    logic [7:0] cur_char;
    logic       advance;

    // Decode run shape of the head job
    always_comb begin
        case (head_job.kind)
            JOB_ESC2: begin prefix_len = 3'd1; digit_cnt = 3'd1; is_hex = 1'b0; end
            JOB_ESC3: begin prefix_len = 3'd2; digit_cnt = 3'd1; is_hex = 1'b0; end
            JOB_HEX3: begin prefix_len = 3'd3; digit_cnt = 3'd3; is_hex = 1'b1; end
            JOB_HEX4: begin prefix_len = 3'd2; digit_cnt = 3'd4; is_hex = 1'b1; end
            JOB_HEX5: begin prefix_len = 3'd2; digit_cnt = 3'd5; is_hex = 1'b1; end
            default:  begin prefix_len = 3'd0; digit_cnt = 3'd1; is_hex = 1'b0; end
        endcase
    end

    assign digit_idx = pos_reg - prefix_len;
    assign last_char = (pos_reg == prefix_len + digit_cnt - 3'd1);

    // Pick the nibble for the current hex digit, most significant first
    always_comb begin
        case (digit_idx)
            3'd0:    nibble = head_job.payload[19:16];
            3'd1:    nibble = head_job.payload[15:12];
            3'd2:    nibble = head_job.payload[11:8];
            3'd3:    nibble = head_job.payload[7:4];
            default: nibble = head_job.payload[3:0];
        endcase
    end

    // Select the character at the current position
    always_comb begin
        if (pos_reg < prefix_len) begin
            case (pos_reg)
                3'd0:    cur_char = CH_BSLASH;
                3'd1:    cur_char = is_hex ? CH_U : CH_BSLASH;
                default: cur_char = CH_ZERO;
            endcase
        end else if (is_hex) begin
            cur_char = hex_char(nibble);
        end else begin
            cur_char = head_job.payload[7:0];
        end
    end

    assign advance = head_valid && (!valid_reg || out_ready);
    assign pop     = advance && last_char;

    // Load the output register and step through the run
    always_comb begin
        pos_next      = pos_reg;
        valid_next    = valid_reg;
        char_next     = char_reg;
        run_last_next = run_last_reg;
        str_end_next  = str_end_reg;
        invalid_next  = invalid_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (advance) begin
            valid_next    = 1'b1;
            char_next     = cur_char;
            run_last_next = last_char;
            str_end_next  = last_char && head_job.str_end;
            invalid_next  = last_char && head_job.invalid;
            pos_next      = last_char ? 3'd0 : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge aclk) begin
        char_reg     <= char_next;
        run_last_reg <= run_last_next;
        str_end_reg  <= str_end_next;
        invalid_reg  <= invalid_next;
    end

    assign out_valid    = valid_reg;
    assign out_char     = char_reg;
    assign out_run_last = run_last_reg;
    assign out_str_end  = str_end_reg;
    assign out_invalid  = invalid_reg;

endmodule

// ----- hw/rtl/utf8_json_string_escaper.sv -----
// ----------------------------------------------------------------------------
// utf8_json_string_escaper - JSON string escaper for UTF-8 text
// Escapes quote, backslash and the control characters BS, FF, LF, CR and TAB,
// and turns multi-byte UTF-8 sequences into backslash-u escapes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one raw string byte per transfer, tlast on the
//   final byte of a string. Output stream m_axis_*: one escaped character
//   per transfer; tlast marks the final character of the string, tuser[0]
//   the final character caused by one input byte, tuser[1] an invalid string
//   (set only together with tlast on a pure end-status character of 0).
//   Each byte's job is registered in the job queue, then each of its
//   characters in the serializer's output register. Throughput: one output
//   character per cycle while m_axis is not stalled; an ASCII byte yields 1
//   to 3 characters, the byte that closes a two- or three-byte sequence 6,
//   one that closes a four-byte sequence 7 (none above the limit), other
//   bytes none. Input is taken every cycle while the job queue has room, so
//   lead and continuation bytes flow without stalls. Reset (aresetn low,
//   synchronous) empties the queue and output register and closes any open
//   sequence. A stall on m_axis_tready holds the output character; the
//   queue then fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module utf8_json_string_escaper
    import ejs_pkg::*;
#(
    parameter int FIFO_DEPTH = EJS_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // string_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast,   // string_end
    output logic [1:0] m_axis_tuser    // [0] run_last, [1] invalid
);

    ejs_job_t front_job;
    ejs_job_t head_job;
    logic     job_valid, job_ready;
    logic     head_valid, head_pop;

    ejs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (front_job)
    );

    ejs_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_valid),
        .push_ready (job_ready),
        .push_job   (front_job),
        .head_valid (head_valid),
        .pop        (head_pop),
        .head_job   (head_job)
    );

    ejs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (head_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_char     (m_axis_tdata),
        .out_run_last (m_axis_tuser[0]),
        .out_str_end  (m_axis_tlast),
        .out_invalid  (m_axis_tuser[1])
    );

endmodule

// ----- hw/rtl/ejs_checker.sv -----
// ----------------------------------------------------------------------------
// ejs_checker - port-level checks for the JSON string escaper
// Watches the output stream for reset behavior and flag consistency.
// ----------------------------------------------------------------------------
module ejs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [1:0] m_axis_tuser
);

    // Output stream is empty right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled character holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled output changed");

    // Invalid is reported only on the end character, which is 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && (m_axis_tdata == 8'd0))
        else $error("invalid flag off the end character");

    // The end of a string also ends the run of its last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("string end without run end");

endmodule

bind utf8_json_string_escaper ejs_checker u_ejs_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking testbench for utf8_json_string_escaper
// Streams UTF-8 strings into the escaper, predicts every escaped character in
// a scoreboard and compares each output transfer field by field. Covers the
// ASCII escapes, every sequence length, dropped four-byte values, bad lead
// bytes and truncated strings, under several backpressure and idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import ejs_pkg::*;

    // One escaped character as it should leave the block
    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       str_end;
        logic       invalid;
    } esc_char_t;

    typedef logic [7:0] byte_q_t[$];

    // Lowercase hex letters: 'a' minus ten
    localparam logic [7:0] HEX_ALPHA_BASE = 8'h57;

    // Predicts escaped output per input byte and checks it against the block
    class esc_scoreboard;
        logic [1:0]  bytes_left;
        logic [2:0]  seq_len;
        logic [20:0] code_point;
        logic        err_seen;
        esc_char_t   step_chars[$];
        esc_char_t   expected_chars[$];
        int          errors;
        int          chars_seen;

        function new();
            bytes_left = '0;
            seq_len    = '0;
            code_point = '0;
            err_seen   = 1'b0;
            errors     = 0;
            chars_seen = 0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        task report(input string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void add_char(input logic [7:0] ch);
            step_chars.push_back('{ch, 1'b0, 1'b0, 1'b0});
        endfunction

        function void add_hex(input logic [20:0] v, input int digits);
            logic [3:0] nib;
            for (int i = digits - 1; i >= 0; i--) begin
                nib = v[4*i +: 4];
                add_char(nib < 4'd10 ? CH_ZERO + nib : HEX_ALPHA_BASE + nib);
            end
        endfunction

        // Note one accepted byte; returns 1 if the block acts on it
        function bit note_byte(input logic [7:0] b, input logic last);
            bit live;
            live = !err_seen;
            step_chars.delete();
            if (err_seen) begin
                // rest of the string is swallowed
            end else if (bytes_left != 0) begin
                code_point = {code_point[14:0], b[5:0]};
                bytes_left = bytes_left - 2'd1;
                if (bytes_left == 0) begin
                    case (seq_len)
                        3'd2: begin
                            add_char(CH_BSLASH);
                            add_char(CH_U);
                            add_char(CH_ZERO);
                            add_hex(code_point, 3);
                        end
                        3'd3: begin
                            add_char(CH_BSLASH);
                            add_char(CH_U);
                            add_hex(code_point, 4);
                        end
                        default: begin
                            // values above the four-byte limit vanish silently
                            if (code_point <= MAX_FOUR_BYTE) begin
                                add_char(CH_BSLASH);
                                add_char(CH_U);
                                add_hex(code_point, 5);
                            end
                        end
                    endcase
                    seq_len    = '0;
                    code_point = '0;
                end
            end else begin
                casez (b)
                    8'b0???????: begin
                        case (b)
                            CH_QUOTE: begin
                                add_char(CH_BSLASH);
                                add_char(CH_QUOTE);
                            end
                            CH_BSLASH: begin
                                add_char(CH_BSLASH);
                                add_char(CH_BSLASH);
                            end
                            CH_BS: begin
                                add_char(CH_BSLASH); add_char(CH_BSLASH); add_char(CH_B);
                            end
                            CH_FF: begin
                                add_char(CH_BSLASH); add_char(CH_BSLASH); add_char(CH_F);
                            end
                            CH_LF: begin
                                add_char(CH_BSLASH); add_char(CH_BSLASH); add_char(CH_N);
                            end
                            CH_CR: begin
                                add_char(CH_BSLASH); add_char(CH_BSLASH); add_char(CH_R);
                            end
                            CH_TAB: begin
                                add_char(CH_BSLASH); add_char(CH_BSLASH); add_char(CH_T);
                            end
                            default: add_char(b);
                        endcase
                    end
                    8'b110?????: begin
                        seq_len = 3'd2; bytes_left = 2'd1; code_point = {16'd0, b[4:0]};
                    end
                    8'b1110????: begin
                        seq_len = 3'd3; bytes_left = 2'd2; code_point = {17'd0, b[3:0]};
                    end
                    8'b11110???: begin
                        seq_len = 3'd4; bytes_left = 2'd3; code_point = {18'd0, b[2:0]};
                    end
                    default: err_seen = 1'b1;
                endcase
            end

            // Close the string: pure status char if nothing else came out
            if (last) begin
                if (step_chars.size() == 0) begin
                    add_char(8'h00);
                    step_chars[0].invalid = err_seen || (bytes_left != 0);
                end
                step_chars[step_chars.size()-1].str_end = 1'b1;
                bytes_left = '0;
                seq_len    = '0;
                code_point = '0;
                err_seen   = 1'b0;
            end
            if (step_chars.size() > 0)
                step_chars[step_chars.size()-1].run_last = 1'b1;
            foreach (step_chars[i])
                expected_chars.push_back(step_chars[i]);
            return live;
        endfunction

        // Compare one output transfer with the oldest expected character
        task check_char(input logic [7:0] ch, input logic rl, input logic se,
                        input logic inv);
            esc_char_t exp_c;
            if (expected_chars.size() == 0) begin
                report($sformatf("char %0d: unexpected output %h", chars_seen, ch));
            end else begin
                exp_c = expected_chars.pop_front();
                if (ch !== exp_c.ch)
                    report($sformatf("char %0d: out_char %h, expected %h",
                                     chars_seen, ch, exp_c.ch));
                if (rl !== exp_c.run_last)
                    report($sformatf("char %0d: run_last %b, expected %b",
                                     chars_seen, rl, exp_c.run_last));
                if (se !== exp_c.str_end)
                    report($sformatf("char %0d: string_end %b, expected %b",
                                     chars_seen, se, exp_c.str_end));
                if (inv !== exp_c.invalid)
                    report($sformatf("char %0d: invalid %b, expected %b",
                                     chars_seen, inv, exp_c.invalid));
            end
            chars_seen++;
        endtask
    endclass

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;

    esc_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int live_bytes     = 0;

    utf8_json_string_escaper dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
        .s_axis_tlast  (s_axis_tlast),   // string_last
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_char
        .m_axis_tlast  (m_axis_tlast),   // string_end
        .m_axis_tuser  (m_axis_tuser)    // [0] run_last, [1] invalid
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("utf8_json_string_escaper test failed");
        $finish;
    end

    // Check each output transfer and randomize backpressure
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_char(m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one byte, with random idle cycles first, and wait for the transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        if (sb.note_byte(b, last))
            live_bytes++;
    endtask

    task automatic send_string(input byte_q_t s);
        foreach (s[i])
            send_byte(s[i], i == s.size() - 1);
    endtask

    // Hold the input until every predicted character has come out
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_ascii();
        logic [7:0] specials[9] = '{CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF,
                                    CH_CR, CH_TAB, 8'h00, 8'h7F};
        if ($urandom_range(1) == 0)
            return specials[$urandom_range(8)];
        return 8'($urandom_range(127));
    endfunction

    function automatic logic [7:0] rand_cont();
        if ($urandom_range(99) < 85)
            return {2'b10, 6'($urandom_range(63))};
        return 8'($urandom_range(255));
    endfunction

    // Build one well-formed-ish string of random tokens, sometimes cut short
    task automatic send_random_string();
        byte_q_t s;
        int      ntok;
        int      pick;
        int      tok_len;
        int      cut;
        ntok    = $urandom_range(1, 10);
        tok_len = 1;
        for (int t = 0; t < ntok; t++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                s.push_back(rand_ascii());
                tok_len = 1;
            end else if (pick < 57) begin
                s.push_back({3'b110, 5'($urandom_range(31))});
                s.push_back(rand_cont());
                tok_len = 2;
            end else if (pick < 74) begin
                s.push_back({4'b1110, 4'($urandom_range(15))});
                s.push_back(rand_cont());
                s.push_back(rand_cont());
                tok_len = 3;
            end else if (pick < 94) begin
                // at least half of these stay at or below the four-byte limit
                if ($urandom_range(1) == 0) begin
                    s.push_back(8'hF0);
                    s.push_back(8'h80 | 8'($urandom_range(16)));
                end else begin
                    s.push_back({5'b11110, 3'($urandom_range(7))});
                    s.push_back(rand_cont());
                end
                s.push_back(rand_cont());
                s.push_back(rand_cont());
                tok_len = 4;
            end else begin
                if ($urandom_range(1) == 0)
                    s.push_back(8'($urandom_range(8'hBF, 8'h80)));
                else
                    s.push_back(8'($urandom_range(8'hFF, 8'hF8)));
                tok_len = 1;
            end
        end
        // truncate inside the final sequence now and then
        if (tok_len > 1 && $urandom_range(9) == 0) begin
            cut = $urandom_range(1, tok_len - 1);
            repeat (cut) s.delete(s.size() - 1);
        end
        send_string(s);
    endtask

    initial begin
        int start_count;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: ASCII escapes, each sequence length, limits and errors
        send_string('{CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB,
                      8'h00, 8'h7F});
        send_string('{8'hC2, 8'hA9, 8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'hBF,
                      8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF});
        send_string('{8'hFF, 8'h41});
        send_string('{8'hE2});

        // Random strings under four idle patterns
        for (int phase = 0; phase < 4; phase++) begin
            wait_drain();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 70; end
                default: begin send_idle_pct = 17; recv_stall_pct <= 17; end
            endcase
            start_count = live_bytes;
            while (live_bytes - start_count < 75)
                send_random_string();
        end

        wait_drain();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("utf8_json_string_escaper test passed");
        else
            $display("utf8_json_string_escaper test failed");
        $finish;
    end

endmodule
